// File: rtl/core/xor_closest_node_search_defines.svh
// ---------------------------------------------------------------------------
// xor closest node search - assertion macros
// shared property wrappers for the closest node search core
// ---------------------------------------------------------------------------
`ifndef XOR_CLOSEST_NODE_SEARCH_DEFINES_SVH
`define XOR_CLOSEST_NODE_SEARCH_DEFINES_SVH

// same-cycle implication, gated by active-low reset
`define XCNS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by active-low reset
`define XCNS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/xcns_pkg.sv
// ---------------------------------------------------------------------------
// xcns_pkg
// types, codes and helpers for the xor closest node search core
// ---------------------------------------------------------------------------
package xcns_pkg;

    // default sizing
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_BYTES_DEF   = 8;

    // fixed field widths
    localparam int KEY_FIELD_W   = 64;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;
    localparam int INDEX_FIELD_W = 4;
    localparam int BUCKET_W      = 7;
    localparam int BYTE_SEL_W    = 3;
    localparam int S_DATA_W      = 2 * KEY_FIELD_W;
    localparam int M_DATA_RAW_W  = COUNT_FIELD_W + INDEX_FIELD_W + KEY_FIELD_W + BUCKET_W + 1;
    localparam int M_DATA_W      = ((M_DATA_RAW_W + 7) / 8) * 8;

    // item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IS_LOCAL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    // bucket code when closest key equals local key
    localparam logic [BUCKET_W-1:0] BUCKET_NONE = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BUCKET,
        ST_DONE
    } xcns_state_t;

    // position of the highest set bit in a byte
    function automatic logic [2:0] top_bit8(input logic [7:0] v);
        logic [2:0] pos;
        pos = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: rtl/core/xcns_ram.sv
// ---------------------------------------------------------------------------
// xcns_ram
// simple dual-port ram, one write and one read port, registered read data
// ---------------------------------------------------------------------------
module xcns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/xor_closest_node_search.sv
// ---------------------------------------------------------------------------
// xor_closest_node_search
// key table with xor-distance closest node lookup, bucket and local test
// ---------------------------------------------------------------------------
//  channel  | ports                | contents
//  ---------+----------------------+------------------------------------------
//  input    | s_axis_t*            | mode, node key, target key
//  result   | m_axis_t*            | status, count, index, key, bucket, flag
//  config   | cfg_valid/ready/data | local key
//
//  clear, append and error items go from the accept straight to the result.
//  a query first scans the filled entries, where the table ram gives one key
//  per cycle to the distance compare, then the bucket is found one key byte
//  per cycle from the top. after reset the table is empty and the local key
//  is zero. a stalled result sits in the output register while the next beat
//  is taken; the core waits in its done state only if that register is still
//  full when the next result is ready.
// ---------------------------------------------------------------------------
`include "xor_closest_node_search_defines.svh"

module xor_closest_node_search
    import xcns_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_DATA_W-1:0]    s_axis_tdata,  // node_key, target_key
    input  logic [MODE_W-1:0]      s_axis_tuser,  // mode
    // result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_DATA_W-1:0]    m_axis_tdata,  // entry_count, closest_index,
                                                  // closest_key, closest_bucket,
                                                  // local_is_closest, zero pad
    output logic [STATUS_W-1:0]    m_axis_tuser,  // status
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [KEY_FIELD_W-1:0] cfg_data       // local_key
);

    localparam int KW = 8 * KEY_BYTES;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    xcns_state_t state_reg, state_next;

    logic [KW-1:0]          local_key_reg, local_key_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [KW-1:0]          target_reg, target_next;
    logic [IW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [KW-1:0]          best_d_reg, best_d_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic [KW-1:0]          best_key_reg, best_key_next;
    logic [BYTE_SEL_W-1:0]  byte_reg, byte_next;
    logic [BUCKET_W-1:0]    bucket_reg, bucket_next;
    logic                   lclose_reg, lclose_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic                   m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]    m_data_reg, m_data_next;
    logic [STATUS_W-1:0]    m_user_reg, m_user_next;

    logic                   s_fire;
    logic                   out_free;
    logic                   ram_we;
    logic [IW-1:0]          ram_raddr;
    logic [KW-1:0]          ram_rdata;
    logic [KW-1:0]          in_node_key;
    logic [KW-1:0]          in_target_key;
    logic                   table_full;
    logic                   target_is_local;
    logic                   scan_last;
    logic [KW-1:0]          scan_dist;
    logic [KEY_FIELD_W-1:0] diff_wide;
    logic [7:0]             diff_byte;
    logic [BUCKET_W-1:0]    bucket_found;

    // handshakes and input decode
    assign s_fire          = s_axis_tvalid && s_axis_tready;
    assign out_free        = !m_valid_reg || m_axis_tready;
    assign in_node_key     = s_axis_tdata[KW-1:0];
    assign in_target_key   = s_axis_tdata[KEY_FIELD_W +: KW];
    assign table_full      = (count_reg == CW'(TABLE_DEPTH));
    assign target_is_local = (in_target_key == local_key_reg);
    assign cfg_ready       = 1'b1;

    // scan compare on the key read last cycle
    assign scan_dist = ram_rdata ^ target_reg;
    assign scan_last = ((CW'(cmp_idx_reg) + CW'(1)) == count_reg);

    // bucket search, one byte of the key difference per cycle
    assign diff_wide    = KEY_FIELD_W'(best_key_reg ^ local_key_reg);
    assign diff_byte    = diff_wide[{byte_reg, 3'b000} +: 8];
    assign bucket_found = {1'b0, byte_reg, top_bit8(diff_byte)};

    // key table
    xcns_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (in_node_key),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser == MODE_QUERY && !target_is_local && count_reg != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_BUCKET;
                end
            end
            ST_BUCKET: begin
                if (diff_byte != '0 || byte_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_raddr     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                ram_we        = s_fire && s_axis_tuser == MODE_APPEND && !table_full;
            end
            ST_SCAN: begin
                // the read past the last entry is never used
                ram_raddr = cmp_idx_reg + IW'(1);
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // datapath
    always_comb begin
        local_key_next = local_key_reg;
        count_next     = count_reg;
        target_next    = target_reg;
        cmp_idx_next   = cmp_idx_reg;
        best_d_next    = best_d_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        byte_next      = byte_reg;
        bucket_next    = bucket_reg;
        lclose_next    = lclose_reg;
        status_next    = status_reg;

        if (cfg_valid && cfg_ready) begin
            local_key_next = cfg_data[KW-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    target_next   = in_target_key;
                    cmp_idx_next  = '0;
                    best_d_next   = '0;
                    best_idx_next = '0;
                    best_key_next = '0;
                    byte_next     = BYTE_SEL_W'(KEY_BYTES - 1);
                    bucket_next   = '0;
                    lclose_next   = 1'b0;
                    status_next   = STATUS_OK;
                    case (s_axis_tuser)
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        MODE_APPEND: begin
                            if (table_full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_QUERY: begin
                            if (target_is_local) begin
                                status_next = STATUS_IS_LOCAL;
                            end else if (count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end
                        end
                        default: begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // ties go to the later entry
                if (cmp_idx_reg == '0 || scan_dist <= best_d_reg) begin
                    best_d_next   = scan_dist;
                    best_idx_next = cmp_idx_reg;
                    best_key_next = ram_rdata;
                end
                cmp_idx_next = cmp_idx_reg + IW'(1);
            end
            ST_BUCKET: begin
                if (diff_byte != '0) begin
                    bucket_next = bucket_found;
                    lclose_next = (local_key_reg ^ target_reg) < best_d_reg;
                end else if (byte_reg == '0) begin
                    bucket_next = BUCKET_NONE;
                    lclose_next = 1'b1;
                end else begin
                    byte_next = byte_reg - BYTE_SEL_W'(1);
                end
            end
            default: begin
                cmp_idx_next = cmp_idx_reg;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_user_next  = status_reg;
            m_data_next  = M_DATA_W'({lclose_reg,
                                      bucket_reg,
                                      KEY_FIELD_W'(best_key_reg),
                                      INDEX_FIELD_W'(best_idx_reg),
                                      COUNT_FIELD_W'(count_reg)});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            local_key_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            local_key_reg <= local_key_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        target_reg   <= target_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        byte_reg     <= byte_next;
        bucket_reg   <= bucket_next;
        lclose_reg   <= lclose_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    // checks
    `XCNS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(TABLE_DEPTH),
        "entry count above table depth")
    `XCNS_ASSERT_NOW(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN,
        count_reg != '0 && CW'(cmp_idx_reg) < count_reg, "scan index outside filled entries")
    `XCNS_ASSERT_NEXT(a_done_loads_out, aclk, aresetn, state_reg == ST_DONE && out_free,
        m_valid_reg && state_reg == ST_IDLE, "finished item not moved to output register")

endmodule

// File: verif/xor_closest_node_search_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// xor_closest_node_search_tb
// self-checking bench: drives clear, append and query beats with random
// gaps, rewrites the local key between idle phases, and compares every
// result beat with a behavioral key table that tracks the xor distance search
// ---------------------------------------------------------------------------
module xor_closest_node_search_tb;
    import xcns_pkg::*;

    // mode code the core leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // result beat layout, lowest field first
    localparam int IDX_LSB   = COUNT_FIELD_W;
    localparam int KEY_LSB   = IDX_LSB + INDEX_FIELD_W;
    localparam int BKT_LSB   = KEY_LSB + KEY_FIELD_W;
    localparam int LOCAL_BIT = BKT_LSB + BUCKET_W;

    // worst query: accept, full scan, bucket search and some margin
    localparam int DRAIN_CYCLES = 2 * (2 + TABLE_DEPTH_DEF + KEY_BYTES_DEF);
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic [INDEX_FIELD_W-1:0] closest_index;
        logic [KEY_FIELD_W-1:0]   closest_key;
        logic [BUCKET_W-1:0]      closest_bucket;
        logic                     local_is_closest;
    } search_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata;
    logic [MODE_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_DATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [KEY_FIELD_W-1:0] cfg_data;

    // behavioral copy of the key table and local key
    logic [KEY_FIELD_W-1:0] key_store [TABLE_DEPTH_DEF];
    int                     stored_count = 0;
    logic [KEY_FIELD_W-1:0] local_key_m  = '0;
    logic [KEY_FIELD_W-1:0] tie_keys [4];

    search_result_t         expected_results [$];
    int                     fail_count    = 0;
    bit                     tx_fast       = 1'b0;
    bit                     rx_fast       = 1'b0;
    int                     rx_hold_cycles = 0;

    xor_closest_node_search i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // table update and closest node search for one accepted beat
    function automatic search_result_t predict_search(input logic [MODE_W-1:0] mode,
                                                      input logic [KEY_FIELD_W-1:0] node_key,
                                                      input logic [KEY_FIELD_W-1:0] target_key);
        search_result_t         r;
        logic [KEY_FIELD_W-1:0] best_dist;
        logic [KEY_FIELD_W-1:0] entry_dist;
        logic [KEY_FIELD_W-1:0] diff;
        int                     best;
        r = '0;
        case (mode)
            MODE_CLEAR: begin
                stored_count = 0;
            end
            MODE_APPEND: begin
                if (stored_count >= TABLE_DEPTH_DEF) begin
                    r.status = STATUS_FULL;
                end else begin
                    key_store[stored_count] = node_key;
                    stored_count++;
                end
            end
            MODE_QUERY: begin
                // local key match wins over an empty table
                if (target_key == local_key_m) begin
                    r.status = STATUS_IS_LOCAL;
                end else if (stored_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    // least distance, later entry wins a tie
                    best      = 0;
                    best_dist = key_store[0] ^ target_key;
                    for (int i = 1; i < stored_count; i++) begin
                        entry_dist = key_store[i] ^ target_key;
                        if (entry_dist <= best_dist) begin
                            best_dist = entry_dist;
                            best      = i;
                        end
                    end
                    r.closest_index = INDEX_FIELD_W'(best);
                    r.closest_key   = key_store[best];
                    // bucket is the top differing bit against the local key
                    diff             = key_store[best] ^ local_key_m;
                    r.closest_bucket = BUCKET_NONE;
                    for (int b = 0; b < KEY_FIELD_W; b++) begin
                        if (diff[b]) begin
                            r.closest_bucket = BUCKET_W'(b);
                        end
                    end
                    r.local_is_closest = (diff == '0) ||
                                         ((local_key_m ^ target_key) < best_dist);
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_FIELD_W'(stored_count);
        return r;
    endfunction

    function automatic string result_text(input search_result_t r);
        return $sformatf("status %0d count %0d index %0d key %h bucket %h local %0b",
                         r.status, r.entry_count, r.closest_index, r.closest_key,
                         r.closest_bucket, r.local_is_closest);
    endfunction

    // key mix: random, near-duplicates for ties, local key, extremes, stored keys
    function automatic logic [KEY_FIELD_W-1:0] draw_key();
        logic [KEY_FIELD_W-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: k = tie_keys[$urandom_range(0, 3)];
            1: k = tie_keys[$urandom_range(0, 3)] ^ (64'd1 << $urandom_range(0, 63));
            2: k = local_key_m;
            3: k = local_key_m ^ (64'd1 << $urandom_range(0, 63));
            4: k = $urandom_range(0, 1) ? '0 : '1;
            5: begin
                if (stored_count > 0) begin
                    k = key_store[$urandom_range(0, stored_count - 1)];
                end
            end
            default: ;
        endcase
        return k;
    endfunction

    // offer one input beat after a random gap, predict on acceptance
    task automatic send_beat(input logic [MODE_W-1:0] mode,
                             input logic [KEY_FIELD_W-1:0] node_key,
                             input logic [KEY_FIELD_W-1:0] target_key);
        int             gap;
        search_result_t predicted;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {target_key, node_key};
        s_axis_tuser  <= mode;
        do @(posedge aclk); while (!s_axis_tready);
        predicted        = predict_search(mode, node_key, target_key);
        expected_results = {expected_results, predicted};
    endtask

    // stop offering and wait until every result beat is back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_local_key(input logic [KEY_FIELD_W-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        local_key_m = value;
    endtask

    // empty table errors, their precedence and the unused mode
    task automatic test_empty_table();
        send_beat(MODE_QUERY, '0, '0);
        send_beat(MODE_QUERY, '0, '1);
        send_beat(MODE_UNUSED, '1, '1);
    endtask

    // key extremes, tie on equal distance, clear then query
    task automatic test_ties_and_extremes();
        send_beat(MODE_APPEND, '0, '0);
        send_beat(MODE_APPEND, '1, '0);
        send_beat(MODE_APPEND, 64'h8000_0000_0000_0000, '1);
        send_beat(MODE_APPEND, 64'h0000_0000_0000_0001, '0);
        send_beat(MODE_APPEND, 64'h8000_0000_0000_0000, '0);
        send_beat(MODE_QUERY, '1, 64'h8000_0000_0000_0000);
        send_beat(MODE_QUERY, '0, 64'h0000_0000_0000_0001);
        send_beat(MODE_QUERY, '0, '1);
        send_beat(MODE_QUERY, '0, 64'h4000_0000_0000_0000);
        send_beat(MODE_CLEAR, '1, '1);
        send_beat(MODE_QUERY, '0, 64'h0000_0000_0000_0005);
    endtask

    // bucket none, local strictly nearer, target equal to local key
    task automatic test_local_key();
        logic [KEY_FIELD_W-1:0] lk;
        lk = 64'hA5A5_A5A5_A5A5_A5A5;
        write_local_key(lk);
        send_beat(MODE_CLEAR, '0, '0);
        send_beat(MODE_APPEND, lk ^ 64'hFF00, '0);
        send_beat(MODE_QUERY, '0, lk ^ 64'h1);
        send_beat(MODE_APPEND, lk, '0);
        send_beat(MODE_QUERY, '0, lk ^ 64'h1);
        send_beat(MODE_QUERY, '0, lk);
        write_local_key('1);
        send_beat(MODE_QUERY, '0, '0);
    endtask

    // long receiver hold while the sender keeps offering beats
    task automatic test_output_backpressure();
        tx_fast        = 1'b1;
        rx_hold_cycles = 300;
        repeat (12) begin
            send_beat($urandom_range(0, 3) == 0 ? MODE_QUERY : MODE_APPEND,
                      draw_key(), draw_key());
        end
        tx_fast = 1'b0;
    endtask

    // sessions: clear, a run of appends, a run of queries, some noise
    task automatic test_random_sessions(input int n_items);
        logic [MODE_W-1:0] mode;
        int                sent;
        int                n_append;
        int                n_query;
        bit                first_session;
        sent          = 0;
        first_session = 1'b1;
        while (sent < n_items) begin
            if (!first_session && $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_local_key('0);
                    1: write_local_key('1);
                    default: write_local_key({$urandom, $urandom});
                endcase
            end
            foreach (tie_keys[j]) tie_keys[j] = {$urandom, $urandom};
            tx_fast  = ($urandom_range(0, 3) == 0);
            rx_fast  = ($urandom_range(0, 3) == 0);
            n_append = first_session ? TABLE_DEPTH_DEF + 2
                                     : $urandom_range(0, TABLE_DEPTH_DEF + 4);
            n_query  = $urandom_range(2, 10);
            for (int i = 0; i < 1 + n_append + n_query; i++) begin
                if (i == 0) begin
                    mode = MODE_CLEAR;
                end else if ($urandom_range(0, 7) == 0) begin
                    mode = MODE_W'($urandom_range(0, 3));
                end else if (i <= n_append) begin
                    mode = MODE_APPEND;
                end else begin
                    mode = MODE_QUERY;
                end
                send_beat(mode, draw_key(), draw_key());
                if (mode != MODE_UNUSED) begin
                    sent++;
                end
            end
            first_session = 1'b0;
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    // result sink: random stall per beat, long hold on request
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = rx_fast ? 0 : $urandom_range(0, 19);
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        search_result_t got;
        search_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status           = m_axis_tuser;
            got.entry_count      = m_axis_tdata[0 +: COUNT_FIELD_W];
            got.closest_index    = m_axis_tdata[IDX_LSB +: INDEX_FIELD_W];
            got.closest_key      = m_axis_tdata[KEY_LSB +: KEY_FIELD_W];
            got.closest_bucket   = m_axis_tdata[BKT_LSB +: BUCKET_W];
            got.local_is_closest = m_axis_tdata[LOCAL_BIT];
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result beat: %s", result_text(got));
                end
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result mismatch at %0t", $time);
                        $display("  expected %s", result_text(want));
                        $display("  actual   %s", result_text(got));
                    end
                end
            end
        end
    end

    // hard stop
    initial begin
        #TIMEOUT_NS;
        $display("xor_closest_node_search verification failed");
        $finish;
    end

    // stimulus sequence
    initial begin
        foreach (tie_keys[j]) tie_keys[j] = '0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_CLEAR;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_ties_and_extremes();
        test_local_key();
        test_output_backpressure();
        test_random_sessions(400);
        wait_results_drained();

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("xor_closest_node_search verification clean");
        end else begin
            $display("xor_closest_node_search verification failed");
        end
        $finish;
    end

endmodule
